// ===== rtl/command_code_mapping_table_unit_macros.svh =====
// Assertion macros used by the table unit back end.
`ifndef COMMAND_CODE_MAPPING_TABLE_UNIT_MACROS_SVH
`define COMMAND_CODE_MAPPING_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CCTU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CCTU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cctu_pkg.sv =====
package cctu_pkg;

  // Table and transfer sizing
  localparam int TABLE_ENTRIES = 8;
  localparam int CHUNK_BYTES   = 32;
  localparam int MAX_TRANSFER  = 256;
  localparam int QUEUE_DEPTH   = 2;

  // Field widths
  localparam int ADDR_W   = 16;
  localparam int IN_LEN_W = 9;
  localparam int LEN_W    = 6;
  localparam int CODE_W   = 3;
  localparam int REM_W    = $clog2(MAX_TRANSFER + 1);

  // Device slot base for programming an entry (informational, slot = code + base)
  localparam logic [7:0] DEVICE_SLOT_BASE = 8'h80;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MAP_FAIL = 2'd1,
    ST_DISCARD  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_ACCESS  = 2'd0,
    K_EMPTY   = 2'd1,
    K_DISCARD = 2'd2
  } kind_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_t;

  // Classified request handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  addr;
    logic [REM_W-1:0]   len;
    logic               rd;
    logic               refuse;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic               prog;
    status_t            status;
    logic               last;
  } res_t;

endpackage

// ===== rtl/cctu_ifs.sv =====
// Request channel
interface cctu_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [cctu_pkg::ADDR_W-1:0]   access_addr;
  logic [cctu_pkg::IN_LEN_W-1:0] transfer_len;
  logic                         is_read;
  logic                         refuse_map_write;

  modport source (output valid, func, access_addr, transfer_len, is_read,
                  refuse_map_write, input ready);
  modport sink   (input valid, func, access_addr, transfer_len, is_read,
                  refuse_map_write, output ready);
endinterface

// Result channel
interface cctu_out_if;
  logic                        valid;
  logic                        ready;
  logic [cctu_pkg::CODE_W-1:0]  command_code;
  logic [cctu_pkg::ADDR_W-1:0]  chunk_addr;
  logic [cctu_pkg::LEN_W-1:0]   chunk_len;
  logic                        program_entry;
  cctu_pkg::status_t           status;
  logic                        last;

  modport source (output valid, command_code, chunk_addr, chunk_len, program_entry,
                  status, last, input ready);
  modport sink   (input valid, command_code, chunk_addr, chunk_len, program_entry,
                  status, last, output ready);
endinterface

// ===== rtl/cctu_front.sv =====
// Accepts requests and classifies them into queue commands.
module cctu_front (
  cctu_in_if.sink         in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output cctu_pkg::cmd_t  push_cmd
);

  logic [cctu_pkg::IN_LEN_W-1:0] sat_len;

  // Handshake goes straight through to the queue
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  // Saturate length and classify
  always_comb begin
    sat_len = (in_ch.transfer_len > cctu_pkg::IN_LEN_W'(cctu_pkg::MAX_TRANSFER)) ?
              cctu_pkg::IN_LEN_W'(cctu_pkg::MAX_TRANSFER) : in_ch.transfer_len;
    push_cmd.addr   = in_ch.access_addr;
    push_cmd.len    = cctu_pkg::REM_W'(sat_len);
    push_cmd.rd     = in_ch.is_read;
    push_cmd.refuse = in_ch.refuse_map_write;
    if (in_ch.func) begin
      push_cmd.kind = cctu_pkg::K_DISCARD;
    end else if (sat_len == '0) begin
      push_cmd.kind = cctu_pkg::K_EMPTY;
    end else begin
      push_cmd.kind = cctu_pkg::K_ACCESS;
    end
  end

endmodule

// ===== rtl/cctu_queue.sv =====
// Short command queue between front and back.
module cctu_queue #(
  parameter int DEPTH = cctu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  cctu_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output cctu_pkg::cmd_t  pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cctu_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/cctu_back.sv =====
// Table engine: one chunk per cycle while out_ch is free, lookup, round-robin refill, result register.
`include "command_code_mapping_table_unit_macros.svh"

module cctu_back #(
  parameter int TABLE_ENTRIES = cctu_pkg::TABLE_ENTRIES,
  parameter int CHUNK_BYTES   = cctu_pkg::CHUNK_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  cctu_pkg::cmd_t  pop_cmd,
  cctu_out_if.source      out_ch
);

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W = cctu_pkg::ADDR_W;
  localparam int LEN_W  = cctu_pkg::LEN_W;
  localparam int REM_W  = cctu_pkg::REM_W;

  // Control
  cctu_pkg::bk_state_t state_r, state_nxt;
  cctu_pkg::cmd_t      cmd_r, cmd_nxt;
  logic                out_vld_r, out_vld_nxt;
  cctu_pkg::res_t      out_r, res_nxt;
  logic [SLOT_W-1:0]   next_slot_r, next_slot_nxt;

  // Mapping table
  logic [TABLE_ENTRIES-1:0] ent_vld_r;
  logic [ADDR_W-1:0]        ent_addr_r [TABLE_ENTRIES];
  logic [LEN_W-1:0]         ent_cnt_r  [TABLE_ENTRIES];
  logic                     ent_we_r   [TABLE_ENTRIES];

  logic                     out_free, load;
  logic [REM_W-1:0]         chunk_rem, rem_after;
  logic [LEN_W-1:0]         chunk_len;
  logic [TABLE_ENTRIES-1:0] match;
  logic                     hit;
  logic [SLOT_W-1:0]        hit_slot;
  logic                     tbl_wr, tbl_wr_zero, tbl_clr;
  logic [SLOT_W-1:0]        tbl_wr_slot;

  assign out_free  = !out_vld_r || out_ch.ready;
  assign pop_ready = (state_r == cctu_pkg::BK_IDLE);

  // Chunk sizing
  always_comb begin
    chunk_rem = (cmd_r.len < REM_W'(CHUNK_BYTES)) ? cmd_r.len : REM_W'(CHUNK_BYTES);
    chunk_len = LEN_W'(chunk_rem);
    rem_after = cmd_r.len - chunk_rem;
  end

  // Parallel compare, first match in index order
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = ent_vld_r[i] && (ent_addr_r[i] == cmd_r.addr) &&
                 (cmd_r.rd ? (ent_cnt_r[i] == chunk_len) : ent_we_r[i]);
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = SLOT_W'(i);
      end
    end
    hit = |match;
  end

  // Next state, result and table updates
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    next_slot_nxt = next_slot_r;
    res_nxt       = '0;
    load          = 1'b0;
    tbl_wr        = 1'b0;
    tbl_wr_zero   = 1'b0;
    tbl_wr_slot   = next_slot_r;
    tbl_clr       = 1'b0;
    case (state_r)
      cctu_pkg::BK_IDLE: begin
        if (pop_valid) begin
          cmd_nxt   = pop_cmd;
          state_nxt = cctu_pkg::BK_RUN;
        end
      end
      cctu_pkg::BK_RUN: begin
        if (out_free) begin
          load = 1'b1;
          case (cmd_r.kind)
            cctu_pkg::K_DISCARD: begin
              tbl_clr        = 1'b1;
              res_nxt.status = cctu_pkg::ST_DISCARD;
              res_nxt.last   = 1'b1;
              state_nxt      = cctu_pkg::BK_IDLE;
            end
            cctu_pkg::K_ACCESS: begin
              res_nxt.addr   = cmd_r.addr;
              res_nxt.len    = chunk_len;
              res_nxt.status = cctu_pkg::ST_OK;
              res_nxt.last   = (rem_after == '0);
              if (hit) begin
                res_nxt.code = cctu_pkg::CODE_W'(hit_slot);
              end else begin
                res_nxt.code  = cctu_pkg::CODE_W'(next_slot_r);
                tbl_wr        = 1'b1;
                next_slot_nxt = (next_slot_r == SLOT_W'(TABLE_ENTRIES - 1)) ?
                                '0 : next_slot_r + 1'b1;
                if (cmd_r.refuse) begin
                  tbl_wr_zero    = 1'b1;
                  res_nxt.status = cctu_pkg::ST_MAP_FAIL;
                  res_nxt.last   = 1'b1;
                end else begin
                  res_nxt.prog = 1'b1;
                end
              end
              cmd_nxt.len  = rem_after;
              cmd_nxt.addr = cmd_r.addr + ADDR_W'(CHUNK_BYTES);
              if (res_nxt.last) begin
                state_nxt = cctu_pkg::BK_IDLE;
              end
            end
            default: begin
              res_nxt.status = cctu_pkg::ST_EMPTY;
              res_nxt.last   = 1'b1;
              state_nxt      = cctu_pkg::BK_IDLE;
            end
          endcase
          out_vld_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = cctu_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cctu_pkg::BK_IDLE;
      out_vld_r   <= 1'b0;
      next_slot_r <= '0;
      ent_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_vld_r   <= out_vld_nxt;
      next_slot_r <= next_slot_nxt;
      if (tbl_clr) begin
        ent_vld_r <= '0;
      end else if (tbl_wr) begin
        ent_vld_r[tbl_wr_slot] <= !tbl_wr_zero;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (load) begin
      out_r <= res_nxt;
    end
    if (tbl_wr && !tbl_wr_zero) begin
      ent_addr_r[tbl_wr_slot] <= cmd_r.addr;
      ent_cnt_r[tbl_wr_slot]  <= chunk_len;
      ent_we_r[tbl_wr_slot]   <= !cmd_r.rd;
    end
  end

  // Result port
  assign out_ch.valid         = out_vld_r;
  assign out_ch.command_code  = out_r.code;
  assign out_ch.chunk_addr    = out_r.addr;
  assign out_ch.chunk_len     = out_r.len;
  assign out_ch.program_entry = out_r.prog;
  assign out_ch.status        = out_r.status;
  assign out_ch.last          = out_r.last;

  // Checks
  `CCTU_ASSERT_NXT(a_discard_clears, load && (res_nxt.status == cctu_pkg::ST_DISCARD), ent_vld_r == '0, "discard left live entries")
  `CCTU_ASSERT_IMP(a_err_is_last, load && (res_nxt.status != cctu_pkg::ST_OK), res_nxt.last, "terminal status without last")
  `CCTU_ASSERT_NXT(a_miss_advances, load && (res_nxt.prog || (res_nxt.status == cctu_pkg::ST_MAP_FAIL)), next_slot_r != $past(next_slot_r), "miss did not advance slot")
  `CCTU_ASSERT_NXT(a_prog_valid, load && res_nxt.prog, ent_vld_r != '0, "programmed entry not marked valid")

endmodule

// ===== rtl/command_code_mapping_table_unit.sv =====
// Channel   Dir  Payload                                              Transaction
// in_ch     in   func, access_addr, transfer_len, is_read,            valid & ready
//                refuse_map_write
// out_ch    out  command_code, chunk_addr, chunk_len, program_entry,  valid & ready
//                status, last
//
// The back end takes a request from the queue while idle, then gives one result
// per chunk, up to ceil(len / CHUNK_BYTES) chunks (at most 8 at defaults); a
// discard or an empty request gives a single result.
// The back end's chunk loop sets the rate: one lookup per cycle while out_ch is free.
// Reset is synchronous, active low; it empties the queue and marks all table entries
// invalid; no clearing pass is needed.
// A stalled result holds the back end; the 2-entry queue accepts until it is full.
module command_code_mapping_table_unit #(
  parameter int TABLE_ENTRIES = cctu_pkg::TABLE_ENTRIES,
  parameter int CHUNK_BYTES   = cctu_pkg::CHUNK_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  cctu_in_if.sink     in_ch,
  cctu_out_if.source  out_ch
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  cctu_pkg::cmd_t push_cmd, pop_cmd;

  cctu_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  cctu_queue #(
    .DEPTH (cctu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  cctu_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CHUNK_BYTES   (CHUNK_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_ch    (out_ch)
  );

endmodule
